// ----- rtl/dns_pkg.sv -----
// Shared types, sizes and codes for the directional neighbor select block.
// No dependencies; the other files, apart from dns_ram, refer to this package by scoped names.

package dns_pkg;

    // Table and coordinate sizing
    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 16;

    // Fixed field widths of the item formats
    localparam int SLOT_W   = 6;
    localparam int EDGE_W   = 16;
    localparam int WCNT_W   = 7;

    // Derived widths
    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int CENTER_W = 2 * COORD_BITS;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SCORE_W  = SQ_W + 1;
    localparam int DIV_W    = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;
    localparam int STEP_W   = $clog2(DIV_W + 1);

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Direction codes
    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_NORTH = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    // Configuration register indexes (selected by paddr[2])
    localparam logic REG_WINDOW_COUNT = 1'b0;
    localparam logic REG_MONOCLE      = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [SLOT_W-1:0]        slot;
        logic signed [EDGE_W-1:0] left_edge;
        logic signed [EDGE_W-1:0] top_edge;
        logic signed [EDGE_W-1:0] right_edge;
        logic signed [EDGE_W-1:0] bottom_edge;
        logic                     present;
        logic [1:0]               direction;
        logic                     cycle_back;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] target_slot;
        logic              found_by_direction;
        logic              no_target;
    } res_t;

    // Classified command passed from the front to the back
    typedef struct packed {
        logic                  op;
        logic [SLOT_W-1:0]     slot;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic                  present;
        logic [1:0]            dir;
        logic                  back;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Take an edge field as a COORD_BITS-bit two's complement value
    function automatic logic [COORD_BITS-1:0] coord_of(input logic [EDGE_W-1:0] e);
        logic [COORD_BITS+EDGE_W-1:0] wide;
        wide = {{COORD_BITS{1'b0}}, e};
        return wide[COORD_BITS-1:0];
    endfunction

    // (a + b) / 2 with truncation toward zero
    function automatic logic [COORD_BITS-1:0] half_sum(input logic [COORD_BITS-1:0] a,
                                                        input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] s;
        logic [COORD_BITS:0] s_adj;
        s     = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        s_adj = s + {{COORD_BITS{1'b0}}, s[COORD_BITS]};
        return s_adj[COORD_BITS:1];
    endfunction

endpackage

// ----- rtl/dns_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module dns_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dns_front.sv -----
// Front end: accepts input items, computes rectangle centers, builds commands.
// Depends on dns_pkg.

module dns_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dns_pkg::in_t         s_data,
    input  dns_pkg::q_status_t   q_status,
    output logic                 push,
    output dns_pkg::cmd_t        push_cmd
);

    // Accept whenever the queue has room
    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    // Classify the item and reduce the rectangle to its center
    always_comb begin
        push_cmd.op      = s_data.operation;
        push_cmd.slot    = s_data.slot;
        push_cmd.cx      = dns_pkg::half_sum(dns_pkg::coord_of(s_data.left_edge),
                                             dns_pkg::coord_of(s_data.right_edge));
        push_cmd.cy      = dns_pkg::half_sum(dns_pkg::coord_of(s_data.top_edge),
                                             dns_pkg::coord_of(s_data.bottom_edge));
        push_cmd.present = s_data.present;
        push_cmd.dir     = s_data.direction;
        push_cmd.back    = s_data.cycle_back;
    end

endmodule

// ----- rtl/dns_queue.sv -----
// Two-entry command queue between the front and the back.
// Depends on dns_pkg.

module dns_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dns_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output dns_pkg::cmd_t      pop_cmd,
    output dns_pkg::q_status_t q_status
);

    dns_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.empty = (cnt_reg == 2'd0);
    assign q_status.full  = (cnt_reg == 2'd2);

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/dns_back.sv -----
// Back end: applies table writes and runs queries (pipelined scan, then
// cyclic fallback by shift-subtract modulo). Depends on dns_pkg and dns_ram.

module dns_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dns_pkg::q_status_t            q_status,
    input  dns_pkg::cmd_t                 pop_cmd,
    output logic                          pop,
    input  logic [dns_pkg::WCNT_W-1:0]    window_count,
    input  logic                          monocle_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dns_pkg::res_t                 m_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRC   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Control state
    logic [2:0]                        state_reg, state_next;
    logic [dns_pkg::MAX_ENTRIES-1:0]   present_reg, present_next;
    logic                              p0_valid_reg, p0_valid_next;
    logic                              p1_valid_reg, p1_valid_next;
    logic                              p2_valid_reg, p2_valid_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              found_reg, found_next;

    // Query context
    logic [dns_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [1:0]                        dir_reg, dir_next;
    logic                              back_reg, back_next;
    logic [dns_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [dns_pkg::COORD_BITS-1:0]    fx_reg, fx_next;
    logic [dns_pkg::COORD_BITS-1:0]    fy_reg, fy_next;
    logic [dns_pkg::CNT_W-1:0]         scan_reg, scan_next;

    // Scan pipeline
    logic [dns_pkg::IDX_W-1:0]         p0_idx_reg, p0_idx_next;
    logic [dns_pkg::IDX_W-1:0]         p1_idx_reg, p1_idx_next;
    logic [dns_pkg::DIFF_W-1:0]        p1_dx_reg, p1_dx_next;
    logic [dns_pkg::DIFF_W-1:0]        p1_dy_reg, p1_dy_next;
    logic [dns_pkg::IDX_W-1:0]         p2_idx_reg, p2_idx_next;
    logic                              p2_elig_reg, p2_elig_next;
    logic [dns_pkg::SQ_W-1:0]          p2_sqx_reg, p2_sqx_next;
    logic [dns_pkg::SQ_W-1:0]          p2_sqy_reg, p2_sqy_next;
    logic [dns_pkg::IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [dns_pkg::SCORE_W-1:0]       best_score_reg, best_score_next;

    // Modulo unit
    logic [dns_pkg::DIV_W-1:0]         num_reg, num_next;
    logic [dns_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [dns_pkg::STEP_W-1:0]        step_reg, step_next;

    // Result
    dns_pkg::res_t                     res_reg, res_next;
    dns_pkg::res_t                     out_data_reg, out_data_next;

    // Memory ports
    logic                              ram_we;
    logic [dns_pkg::IDX_W-1:0]         ram_waddr;
    logic [dns_pkg::CENTER_W-1:0]      ram_wdata;
    logic [dns_pkg::IDX_W-1:0]         ram_raddr;
    logic [dns_pkg::CENTER_W-1:0]      ram_rdata;

    dns_ram #(
        .DATA_W (dns_pkg::CENTER_W),
        .DEPTH  (dns_pkg::MAX_ENTRIES)
    ) u_centers (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    assign pop     = (state_reg == S_IDLE) && !q_status.empty;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Sequencer, scan pipeline and modulo steps
    always_comb begin
        logic [dns_pkg::CNT_W-1:0]    wc_eff;
        logic                         slot_lt_cnt;
        logic [dns_pkg::IDX_W-1:0]    src_idx;
        logic                         src_ok;
        logic [dns_pkg::SLOT_W-1:0]   m_slot;
        logic [dns_pkg::CNT_W-1:0]    m_count;
        logic                         m_back;
        logic [dns_pkg::DIV_W-1:0]    dividend;
        logic [dns_pkg::COORD_BITS-1:0] rx;
        logic [dns_pkg::COORD_BITS-1:0] ry;
        logic [dns_pkg::DIFF_W-1:0]   ax;
        logic [dns_pkg::DIFF_W-1:0]   ay;
        logic                         cone_ok;
        logic [dns_pkg::SCORE_W-1:0]  score;
        logic [dns_pkg::CNT_W:0]      trial;

        state_next      = state_reg;
        present_next    = present_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        dir_next        = dir_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        scan_next       = scan_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        p0_valid_next   = 1'b0;
        p0_idx_next     = p0_idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = dns_pkg::IDX_W'(pop_cmd.slot);
        ram_wdata       = {pop_cmd.cx, pop_cmd.cy};
        ram_raddr       = scan_reg[dns_pkg::IDX_W-1:0];

        // Clamp the window count to the table size
        if (window_count > dns_pkg::WCNT_W'(dns_pkg::MAX_ENTRIES)) begin
            wc_eff = dns_pkg::CNT_W'(dns_pkg::MAX_ENTRIES);
        end else begin
            wc_eff = dns_pkg::CNT_W'(window_count);
        end
        slot_lt_cnt = dns_pkg::DIV_W'(pop_cmd.slot) < dns_pkg::DIV_W'(wc_eff);
        src_idx     = dns_pkg::IDX_W'(pop_cmd.slot);
        src_ok      = !monocle_mode && slot_lt_cnt && present_reg[src_idx];

        // Fallback dividend from the popped command or the held query
        if (state_reg == S_IDLE) begin
            m_slot  = pop_cmd.slot;
            m_count = wc_eff;
            m_back  = pop_cmd.back;
        end else begin
            m_slot  = slot_reg;
            m_count = count_reg;
            m_back  = back_reg;
        end
        if (m_back) begin
            dividend = dns_pkg::DIV_W'(m_slot) + dns_pkg::DIV_W'(m_count)
                       - dns_pkg::DIV_W'(1);
        end else begin
            dividend = dns_pkg::DIV_W'(m_slot) + dns_pkg::DIV_W'(1);
        end

        // Stage 1: offsets from the source center
        rx            = ram_rdata[dns_pkg::CENTER_W-1:dns_pkg::COORD_BITS];
        ry            = ram_rdata[dns_pkg::COORD_BITS-1:0];
        p1_valid_next = p0_valid_reg;
        p1_idx_next   = p0_idx_reg;
        p1_dx_next    = {rx[dns_pkg::COORD_BITS-1], rx}
                        - {fx_reg[dns_pkg::COORD_BITS-1], fx_reg};
        p1_dy_next    = {ry[dns_pkg::COORD_BITS-1], ry}
                        - {fy_reg[dns_pkg::COORD_BITS-1], fy_reg};

        // Stage 2: cone test and squares
        ax = p1_dx_reg[dns_pkg::DIFF_W-1] ? (~p1_dx_reg + 1'b1) : p1_dx_reg;
        ay = p1_dy_reg[dns_pkg::DIFF_W-1] ? (~p1_dy_reg + 1'b1) : p1_dy_reg;
        case (dir_reg)
            dns_pkg::DIR_WEST: begin
                cone_ok = p1_dx_reg[dns_pkg::DIFF_W-1] && (ax >= ay);
            end
            dns_pkg::DIR_EAST: begin
                cone_ok = !p1_dx_reg[dns_pkg::DIFF_W-1] && (p1_dx_reg != '0) && (ax >= ay);
            end
            dns_pkg::DIR_NORTH: begin
                cone_ok = p1_dy_reg[dns_pkg::DIFF_W-1] && (ay >= ax);
            end
            default: begin
                cone_ok = !p1_dy_reg[dns_pkg::DIFF_W-1] && (p1_dy_reg != '0) && (ay >= ax);
            end
        endcase
        p2_valid_next = p1_valid_reg;
        p2_idx_next   = p1_idx_reg;
        p2_elig_next  = cone_ok && present_reg[p1_idx_reg]
                        && (p1_idx_reg != dns_pkg::IDX_W'(slot_reg));
        p2_sqx_next   = ax * ax;
        p2_sqy_next   = ay * ay;

        // Stage 3: keep the nearest; strict compare keeps the lowest index on ties
        score = dns_pkg::SCORE_W'(p2_sqx_reg) + dns_pkg::SCORE_W'(p2_sqy_reg);
        if (p2_valid_reg && p2_elig_reg && (!found_reg || (score < best_score_reg))) begin
            found_next      = 1'b1;
            best_idx_next   = p2_idx_reg;
            best_score_next = score;
        end

        // Shift-subtract modulo step
        trial = {rem_reg, num_reg[dns_pkg::DIV_W-1]};

        case (state_reg)
            S_IDLE: begin
                if (!q_status.empty) begin
                    if (pop_cmd.op == dns_pkg::OP_WRITE) begin
                        if (dns_pkg::DIV_W'(pop_cmd.slot)
                                < dns_pkg::DIV_W'(dns_pkg::MAX_ENTRIES)) begin
                            ram_we                = 1'b1;
                            present_next[src_idx] = pop_cmd.present;
                        end
                    end else begin
                        slot_next  = pop_cmd.slot;
                        dir_next   = pop_cmd.dir;
                        back_next  = pop_cmd.back;
                        count_next = wc_eff;
                        if (wc_eff == '0) begin
                            res_next.target_slot        = '0;
                            res_next.found_by_direction = 1'b0;
                            res_next.no_target          = 1'b1;
                            state_next                  = S_OUT;
                        end else if (src_ok) begin
                            ram_raddr  = src_idx;
                            state_next = S_SRC;
                        end else begin
                            num_next   = dividend;
                            rem_next   = '0;
                            step_next  = '0;
                            state_next = S_MOD;
                        end
                    end
                end
            end
            S_SRC: begin
                fx_next    = ram_rdata[dns_pkg::CENTER_W-1:dns_pkg::COORD_BITS];
                fy_next    = ram_rdata[dns_pkg::COORD_BITS-1:0];
                scan_next  = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                p0_valid_next = 1'b1;
                p0_idx_next   = scan_reg[dns_pkg::IDX_W-1:0];
                scan_next     = scan_reg + 1'b1;
                if (scan_reg == count_reg - 1'b1) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!p0_valid_reg && !p1_valid_reg && !p2_valid_reg) begin
                    if (found_reg) begin
                        res_next.target_slot        = dns_pkg::SLOT_W'(best_idx_reg);
                        res_next.found_by_direction = 1'b1;
                        res_next.no_target          = 1'b0;
                        state_next                  = S_OUT;
                    end else begin
                        num_next   = dividend;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (trial >= {1'b0, count_reg}) begin
                    rem_next = dns_pkg::CNT_W'(trial - {1'b0, count_reg});
                end else begin
                    rem_next = dns_pkg::CNT_W'(trial);
                end
                num_next  = num_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == dns_pkg::STEP_W'(dns_pkg::DIV_W - 1)) begin
                    res_next.target_slot        = dns_pkg::SLOT_W'(rem_next);
                    res_next.found_by_direction = 1'b0;
                    res_next.no_target          = 1'b0;
                    state_next                  = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            p0_valid_reg  <= p0_valid_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        dir_reg        <= dir_next;
        back_reg       <= back_next;
        count_reg      <= count_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        scan_reg       <= scan_next;
        p0_idx_reg     <= p0_idx_next;
        p1_idx_reg     <= p1_idx_next;
        p1_dx_reg      <= p1_dx_next;
        p1_dy_reg      <= p1_dy_next;
        p2_idx_reg     <= p2_idx_next;
        p2_elig_reg    <= p2_elig_next;
        p2_sqx_reg     <= p2_sqx_next;
        p2_sqy_reg     <= p2_sqy_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        res_reg        <= res_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ----- rtl/directional_neighbor_select.sv -----
// Directional neighbor select: a table of entry centers searched for the nearest
// neighbor in a direction. An accepted item waits in a two-entry queue until the
// engine is idle and takes it. A table write is taken from the queue and applied
// without leaving the idle state, so writes stream at one per cycle while no
// query holds the engine. A query whose source entry is present is taken, reads
// the source center, then reads one center per cycle from the single read port of
// the center memory, drains the three-stage compare pipeline and loads the result
// register; when its cone is empty it falls back to cyclic stepping, which runs a
// shift-subtract modulo one bit per cycle. A query with a zero count goes straight
// to the result register, and one whose source is absent or beyond the count, or
// that runs in monocle mode, goes straight to the modulo stepping. A result
// register lets the next item start while a result waits. Configuration is to be
// written through the APB port only while idle; the block does not enforce it.
// Depends on dns_pkg, dns_front, dns_queue, dns_back and dns_ram.

module directional_neighbor_select (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dns_pkg::in_t         s_data,
    // Result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output dns_pkg::res_t        m_data,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [dns_pkg::WCNT_W-1:0] window_count_reg, window_count_next;
    logic                       monocle_reg, monocle_next;
    logic                       cfg_write;

    dns_pkg::q_status_t         q_status;
    logic                       push;
    dns_pkg::cmd_t              push_cmd;
    logic                       pop;
    dns_pkg::cmd_t              pop_cmd;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        window_count_next = window_count_reg;
        monocle_next      = monocle_reg;
        if (cfg_write) begin
            case (paddr[2])
                dns_pkg::REG_WINDOW_COUNT: begin
                    window_count_next = pwdata[dns_pkg::WCNT_W-1:0];
                end
                default: begin
                    monocle_next = pwdata[0];
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dns_pkg::REG_WINDOW_COUNT: begin
                prdata = {{(32 - dns_pkg::WCNT_W){1'b0}}, window_count_reg};
            end
            default: begin
                prdata = {31'b0, monocle_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_count_reg <= '0;
            monocle_reg      <= 1'b0;
        end else begin
            window_count_reg <= window_count_next;
            monocle_reg      <= monocle_next;
        end
    end

    dns_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    dns_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .pop_cmd      (pop_cmd),
        .pop          (pop),
        .window_count (window_count_reg),
        .monocle_mode (monocle_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // A real target always lies inside the window
    a_target_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.no_target)
            |-> (dns_pkg::WCNT_W'(m_data.target_slot) < window_count_reg))
        else $error("result target outside the window");

    // No target is flagged exactly when the window is empty
    a_no_target_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.no_target == (window_count_reg == '0)))
        else $error("no_target disagrees with window count");

    // An accepted item is queued for the back end
    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !q_status.empty)
        else $error("accepted item missing from queue");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for directional_neighbor_select: directed and random table
// writes and neighbor queries, predicted in-bench and checked at the result port.
// Depends on dns_pkg and the directional_neighbor_select RTL.

module tb_top;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    dns_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    dns_pkg::res_t m_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Bench copy of the table and the registers
    logic signed [dns_pkg::COORD_BITS-1:0] center_x [dns_pkg::MAX_ENTRIES];
    logic signed [dns_pkg::COORD_BITS-1:0] center_y [dns_pkg::MAX_ENTRIES];
    logic [dns_pkg::MAX_ENTRIES-1:0]       entry_live;
    logic [dns_pkg::WCNT_W-1:0]            cfg_window_count;
    logic                                  cfg_monocle;

    dns_pkg::res_t pending_targets [$];
    int            fail_count;
    int            send_idle_pct;
    int            recv_idle_pct;

    directional_neighbor_select dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Expected result of one query against the current table and registers
    function automatic dns_pkg::res_t pick_neighbor(input dns_pkg::in_t q);
        dns_pkg::res_t r;
        int            n, src, i, best;
        longint        dx, dy, ax, ay, sq_dist, best_sq;
        bit            hit, in_cone;
        r = '0;
        n = (cfg_window_count > dns_pkg::MAX_ENTRIES) ? dns_pkg::MAX_ENTRIES
                                                      : int'(cfg_window_count);
        src = int'(q.slot);
        if (n == 0) begin
            r.no_target = 1'b1;
            return r;
        end
        hit = 1'b0;
        best = 0;
        best_sq = 0;
        // scan the cone of the query direction, nearest first, lowest index on a tie
        if (!cfg_monocle && src < n && entry_live[src]) begin
            for (i = 0; i < n; i++) begin
                if (i != src && entry_live[i]) begin
                    dx = longint'(center_x[i]) - longint'(center_x[src]);
                    dy = longint'(center_y[i]) - longint'(center_y[src]);
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    case (q.direction)
                        dns_pkg::DIR_WEST:  in_cone = (dx < 0) && (ax >= ay);
                        dns_pkg::DIR_EAST:  in_cone = (dx > 0) && (ax >= ay);
                        dns_pkg::DIR_NORTH: in_cone = (dy < 0) && (ay >= ax);
                        default:            in_cone = (dy > 0) && (ay >= ax);
                    endcase
                    sq_dist = dx * dx + dy * dy;
                    if (in_cone && (!hit || sq_dist < best_sq)) begin
                        hit = 1'b1;
                        best = i;
                        best_sq = sq_dist;
                    end
                end
            end
        end
        // fall back to cyclic stepping from the slot as given
        if (hit) begin
            r.target_slot = dns_pkg::SLOT_W'(best);
        end else if (q.cycle_back) begin
            r.target_slot = dns_pkg::SLOT_W'((src + n - 1) % n);
        end else begin
            r.target_slot = dns_pkg::SLOT_W'((src + 1) % n);
        end
        r.found_by_direction = hit;
        return r;
    endfunction

    function automatic dns_pkg::in_t rect_item(input int slot, input int l, input int t,
                                               input int r, input int b, input bit live);
        dns_pkg::in_t it;
        it = '0;
        it.operation   = dns_pkg::OP_WRITE;
        it.slot        = dns_pkg::SLOT_W'(slot);
        it.left_edge   = dns_pkg::EDGE_W'(l);
        it.top_edge    = dns_pkg::EDGE_W'(t);
        it.right_edge  = dns_pkg::EDGE_W'(r);
        it.bottom_edge = dns_pkg::EDGE_W'(b);
        it.present     = live;
        return it;
    endfunction

    function automatic dns_pkg::in_t query_item(input int slot, input logic [1:0] dir,
                                                input bit back);
        dns_pkg::in_t it;
        it = '0;
        it.operation  = dns_pkg::OP_QUERY;
        it.slot       = dns_pkg::SLOT_W'(slot);
        it.direction  = dir;
        it.cycle_back = back;
        return it;
    endfunction

    // Full-range edge when span is zero, else a value within +-span
    function automatic logic [dns_pkg::EDGE_W-1:0] rand_edge(input int span);
        if (span == 0) begin
            return dns_pkg::EDGE_W'($urandom());
        end
        return dns_pkg::EDGE_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Send one item, with random idle cycles ahead of it, and record its effect
    task automatic send_item(input dns_pkg::in_t item);
        int cx, cy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (item.operation == dns_pkg::OP_QUERY) begin
            pending_targets.push_back(pick_neighbor(item));
        end else begin
            cx = ($signed(item.left_edge) + $signed(item.right_edge)) / 2;
            cy = ($signed(item.top_edge) + $signed(item.bottom_edge)) / 2;
            center_x[item.slot]   = dns_pkg::COORD_BITS'(cx);
            center_y[item.slot]   = dns_pkg::COORD_BITS'(cy);
            entry_live[item.slot] = item.present;
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_targets.size() != 0);
    endtask

    // Let queued table writes finish before touching a register
    task automatic settle_engine();
        wait_drained();
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == dns_pkg::REG_WINDOW_COUNT) begin
            cfg_window_count = value[dns_pkg::WCNT_W-1:0];
        end else begin
            cfg_monocle = value[0];
        end
        @(posedge aclk);
    endtask

    // Queries with a zero count right after reset
    task automatic test_zero_count();
        send_item(query_item(0, dns_pkg::DIR_WEST, 1'b0));
        send_item(query_item(63, dns_pkg::DIR_SOUTH, 1'b1));
    endtask

    // Extreme centers, odd negative sums, diagonal entries and an equal-distance pair
    task automatic test_directional_search();
        settle_engine();
        write_register(dns_pkg::REG_WINDOW_COUNT, 8);
        send_item(rect_item(0, -3, -3, 0, 0, 1'b1));
        send_item(rect_item(1, -32768, -1, -32768, -1, 1'b1));
        send_item(rect_item(2, 32767, -32768, 32767, 32767, 1'b1));
        send_item(rect_item(3, -1, -32768, 1, -32768, 1'b1));
        send_item(rect_item(4, -1, 32767, -1, 32767, 1'b1));
        send_item(rect_item(5, 1, -1, 3, -1, 1'b1));
        send_item(rect_item(6, 1, -2, 3, 0, 1'b1));
        send_item(rect_item(7, -4, 0, -2, 2, 1'b1));
        send_item(query_item(0, dns_pkg::DIR_WEST, 1'b0));
        send_item(query_item(0, dns_pkg::DIR_EAST, 1'b0));
        send_item(query_item(0, dns_pkg::DIR_NORTH, 1'b1));
        send_item(query_item(0, dns_pkg::DIR_SOUTH, 1'b1));
        send_item(query_item(2, dns_pkg::DIR_WEST, 1'b0));
        send_item(query_item(3, dns_pkg::DIR_SOUTH, 1'b0));
        send_item(query_item(1, dns_pkg::DIR_EAST, 1'b1));
    endtask

    // Absent source, source beyond the count, and an empty cone
    task automatic test_fallback_stepping();
        send_item(rect_item(5, 0, 0, 0, 0, 1'b0));
        send_item(query_item(5, dns_pkg::DIR_EAST, 1'b0));
        send_item(query_item(5, dns_pkg::DIR_EAST, 1'b1));
        send_item(query_item(63, dns_pkg::DIR_WEST, 1'b0));
        send_item(query_item(63, dns_pkg::DIR_WEST, 1'b1));
        send_item(query_item(2, dns_pkg::DIR_EAST, 1'b0));
        send_item(query_item(2, dns_pkg::DIR_EAST, 1'b1));
    endtask

    // Monocle forces stepping; a count above the table acts as the full table
    task automatic test_monocle_and_count_clamp();
        settle_engine();
        write_register(dns_pkg::REG_MONOCLE, 1);
        send_item(query_item(0, dns_pkg::DIR_EAST, 1'b1));
        settle_engine();
        write_register(dns_pkg::REG_MONOCLE, 0);
        write_register(dns_pkg::REG_WINDOW_COUNT, 127);
        send_item(query_item(63, dns_pkg::DIR_NORTH, 1'b0));
        send_item(query_item(0, dns_pkg::DIR_NORTH, 1'b1));
    endtask

    // Random settings, each followed by a write-heavy fill and a query-heavy tail
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int total);
        int           sent, k, chunk, span, n;
        dns_pkg::in_t it;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < total) begin
            settle_engine();
            case ($urandom_range(9))
                0:       write_register(dns_pkg::REG_WINDOW_COUNT, 0);
                1:       write_register(dns_pkg::REG_WINDOW_COUNT,
                                        $urandom_range(127, dns_pkg::MAX_ENTRIES + 1));
                2:       write_register(dns_pkg::REG_WINDOW_COUNT, 1);
                3:       write_register(dns_pkg::REG_WINDOW_COUNT, dns_pkg::MAX_ENTRIES);
                default: write_register(dns_pkg::REG_WINDOW_COUNT,
                                        $urandom_range(dns_pkg::MAX_ENTRIES, 2));
            endcase
            write_register(dns_pkg::REG_MONOCLE, 32'($urandom_range(7) == 0));
            n = (cfg_window_count > dns_pkg::MAX_ENTRIES) ? dns_pkg::MAX_ENTRIES
                                                          : int'(cfg_window_count);
            chunk = $urandom_range(100, 60);
            case ($urandom_range(3))
                0:       span = 0;
                1:       span = 8;
                2:       span = 200;
                default: span = 5000;
            endcase
            for (k = 0; k < chunk && sent < total; k++) begin
                it.operation = ($urandom_range(99) < ((k < chunk / 4) ? 80 : 30)) ?
                               dns_pkg::OP_WRITE : dns_pkg::OP_QUERY;
                if (n > 0 && $urandom_range(9) < 8) begin
                    it.slot = dns_pkg::SLOT_W'($urandom_range(n - 1));
                end else begin
                    it.slot = dns_pkg::SLOT_W'($urandom_range(63));
                end
                it.left_edge   = rand_edge(span);
                it.top_edge    = rand_edge(span);
                it.right_edge  = rand_edge(span);
                it.bottom_edge = rand_edge(span);
                it.present     = ($urandom_range(99) < 85);
                it.direction   = 2'($urandom_range(3));
                it.cycle_back  = 1'($urandom_range(1));
                send_item(it);
                sent++;
                if ($urandom_range(49) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    // Drive the result-side stall and check each result against the oldest expectation
    always @(posedge aclk) begin
        dns_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_targets.size() == 0) begin
                report_mismatch("result with no query outstanding");
            end else begin
                want = pending_targets.pop_front();
                if (m_data.target_slot !== want.target_slot) begin
                    report_mismatch($sformatf("target_slot %0d, expected %0d",
                                              m_data.target_slot, want.target_slot));
                end
                if (m_data.found_by_direction !== want.found_by_direction) begin
                    report_mismatch($sformatf("found_by_direction %0b, expected %0b",
                                              m_data.found_by_direction,
                                              want.found_by_direction));
                end
                if (m_data.no_target !== want.no_target) begin
                    report_mismatch($sformatf("no_target %0b, expected %0b",
                                              m_data.no_target, want.no_target));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        aresetn <= 1'b0;
        entry_live       = '0;
        cfg_window_count = '0;
        cfg_monocle      = 1'b0;
        fail_count       = 0;
        send_idle_pct    = 22;
        recv_idle_pct    = 48;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_count();
        test_directional_search();
        test_fallback_stepping();
        test_monocle_and_count_clamp();
        test_random_traffic(22, 48, 574);
        test_random_traffic(48, 22, 574);
        test_random_traffic(0, 0, 574);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
